/* rtl/fspa_pkg.sv */
package fspa_pkg;

	localparam int NUM_SLOTS_DEF = 256;
	localparam int IDX_W         = 8;
	localparam int CNT_W         = 9;
	localparam int SLICE_W       = 13;
	localparam int ADDR_W        = 20;
	localparam int STAT_W        = 2;
	localparam int MAX_COUNT     = 256;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	localparam logic REG_SLOT_COUNT = 1'b0;
	localparam logic REG_SLICE_SIZE = 1'b1;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [IDX_W-1:0] data;
	} link_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} link_rd_t;

endpackage

/* rtl/fspa_link_ram.sv */
module fspa_link_ram import fspa_pkg::*; #(
	parameter int DEPTH = NUM_SLOTS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  link_wr_t         wr,
	input  link_rd_t         rd,
	output logic [IDX_W-1:0] rdata
);

	logic [IDX_W-1:0] mem [DEPTH];
	logic [IDX_W-1:0] rd_q;
	logic [IDX_W-1:0] fwd_data_q;
	logic             fwd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
		if (rd.en) begin
			rd_q       <= mem[rd.addr[AW-1:0]];
			fwd_data_q <= wr.data;
		end
	end

	// same-entry write and read in one cycle: new data wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd.en) begin
			fwd_q <= wr.en && (wr.addr[AW-1:0] == rd.addr[AW-1:0]);
		end
	end

	assign rdata = fwd_q ? fwd_data_q : rd_q;

endmodule

/* rtl/fixed_slot_pool_allocator.sv */
// Channel | Dir | Fields
// s_axis  | in  | tuser[0] command; tdata[7:0] free_index
// m_axis  | out | tuser[1:0] status; tdata slot_index, slot_address, free_count
// cfg     | in  | cfg_index 0 slot_count, 1 slice_size; cfg_data value
//
// A free completes from S_IDLE; an allocate that leaves slots free also
// passes through S_FETCH, waiting on the link memory read that forms the new head.
// Results sit in an output register; a new request is taken while the
// current result is being taken, but not in S_FETCH. arst_n clears the pool to
// slot_count min(NUM_SLOTS, 256), slice_size 64, all slots free; link memory contents are not reset.
module fixed_slot_pool_allocator import fspa_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,  // [7:0] free_index
	input  logic [0:0]         s_axis_tuser,  // [0] command
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [39:0]        m_axis_tdata,  // [7:0] slot_index, [27:8] slot_address,
	                                          // [36:28] free_count, [39:37] zero
	output logic [STAT_W-1:0]  m_axis_tuser,  // [1:0] status
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [SLICE_W-1:0] cfg_data
);

	localparam int CAP   = (NUM_SLOTS < MAX_COUNT) ? NUM_SLOTS : MAX_COUNT;
	localparam int AW    = (CAP > 1) ? $clog2(CAP) : 1;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAP);
	localparam logic [CNT_W-1:0] FREE_MAX = {CNT_W{1'b1}};

	localparam logic S_IDLE  = 1'b0;
	localparam logic S_FETCH = 1'b1;

	logic               state_q;
	logic [CNT_W-1:0]   count_q;
	logic [SLICE_W-1:0] slice_q;
	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   free_q;
	logic [CNT_W-1:0]   linked_q;

	logic               out_valid_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [IDX_W-1:0]   out_index_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [CNT_W-1:0]   out_free_q;

	logic               accept;
	logic               is_alloc;
	logic [IDX_W-1:0]   fi;
	logic               fi_ok;
	logic               lazy_en;
	logic [CNT_W-1:0]   linked_inc;
	logic [CNT_W-1:0]   free_dec;
	logic [CNT_W-1:0]   cfg_count;
	logic [IDX_W+SLICE_W-1:0] prod;
	link_wr_t           wr;
	link_rd_t           rd;
	logic [IDX_W-1:0]   rdata;

	assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_alloc      = (s_axis_tuser[0] == CMD_ALLOC);
	assign fi            = s_axis_tdata;
	assign fi_ok         = {1'b0, fi} < count_q;
	assign lazy_en       = linked_q < count_q;
	assign linked_inc    = linked_q + CNT_W'(1);
	assign free_dec      = free_q - CNT_W'(1);
	assign cfg_count     = (cfg_data[CNT_W-1:0] > CAP_C) ? CAP_C : cfg_data[CNT_W-1:0];
	assign prod          = {{SLICE_W{1'b0}}, head_q} * {{IDX_W{1'b0}}, slice_q};

	always_comb begin
		wr.en   = 1'b0;
		wr.addr = linked_q[IDX_W-1:0];
		wr.data = linked_inc[IDX_W-1:0];
		rd.en   = 1'b0;
		rd.addr = head_q;
		if (accept) begin
			if (is_alloc) begin
				wr.en = lazy_en;
				rd.en = (free_q != '0) && (free_dec != '0);
			end else begin
				wr.en   = fi_ok;
				wr.addr = fi;
				wr.data = head_q;
			end
		end
	end

	fspa_link_ram #(
		.DEPTH(CAP),
		.AW   (AW)
	) u_link_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= CAP_C;
			slice_q     <= SLICE_W'(64);
			head_q      <= '0;
			free_q      <= CAP_C;
			linked_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SLOT_COUNT: begin
						count_q  <= cfg_count;
						free_q   <= cfg_count;
						linked_q <= '0;
						head_q   <= '0;
					end
					REG_SLICE_SIZE: slice_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_alloc) begin
							if (lazy_en) begin
								linked_q <= linked_inc;
							end
							if (free_q != '0) begin
								free_q <= free_dec;
								if (free_dec != '0) begin
									state_q <= S_FETCH;
								end
							end
						end else if (fi_ok) begin
							head_q <= fi;
							if (free_q != FREE_MAX) begin
								free_q <= free_q + CNT_W'(1);
							end
						end
					end
				end
				S_FETCH: begin
					head_q  <= rdata;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_index_q <= '0;
			out_addr_q  <= '0;
			if (is_alloc) begin
				if (free_q != '0) begin
					out_status_q <= STAT_OK;
					out_index_q  <= head_q;
					out_addr_q   <= prod[ADDR_W-1:0];
					out_free_q   <= free_dec;
				end else begin
					out_status_q <= STAT_EMPTY;
					out_free_q   <= free_q;
				end
			end else if (fi_ok) begin
				out_status_q <= STAT_OK;
				out_free_q   <= (free_q != FREE_MAX) ? free_q + CNT_W'(1) : free_q;
			end else begin
				out_status_q <= STAT_RANGE;
				out_free_q   <= free_q;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {3'b000, out_free_q, out_addr_q, out_index_q};

endmodule

/* rtl/fspa_checker.sv */
module fspa_checker import fspa_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tvalid,
	input logic               s_axis_tready,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [39:0]        m_axis_tdata,
	input logic [STAT_W-1:0]  m_axis_tuser
);

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted request produced no result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_EMPTY ||
			m_axis_tuser == STAT_RANGE))
		else $error("bad status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata[27:0] == '0)
		else $error("failed request returned a slot");

	a_index_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[7:0] == '0 |-> m_axis_tdata[27:8] == '0)
		else $error("slot zero with nonzero address");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
			$stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
